// ===== rtl/core/swas_pkg.sv =====
package swas_pkg;

	localparam int WINDOW_LEN_DEF = 256;

	localparam int CNT_W      = 9;
	localparam int STD_W      = 19;
	localparam int LIM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SMP_W      = 16;
	localparam int XW         = 18;
	localparam int MEAN_W     = 34;
	localparam int SUM_W      = 48;
	localparam int SUMX_W     = 56;
	localparam int WK_W       = 40;
	localparam int DVD_W      = 48;
	localparam int DVS_W      = 9;
	localparam int MB_W       = 29;
	localparam int PROD_W     = 60;
	localparam int ROOT_STEPS = DVD_W / 2;
	localparam int STEP_W     = 6;
	localparam int FRAC_SH    = 16;

	localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

	typedef struct packed {
		logic [15:0] roll_cdeg;
		logic [14:0] pitch_cdeg;
		logic [15:0] yaw_cdeg;
		logic        advance;
		logic        accumulate;
		logic        clear;
	} in_word_t;

	typedef struct packed {
		logic [STD_W-1:0] roll_std;
		logic [STD_W-1:0] pitch_std;
		logic [STD_W-1:0] yaw_std;
		logic             steady;
		logic [CNT_W-1:0] samples_seen;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROLL_LIM  = 2'd0,
		REG_PITCH_LIM = 2'd1,
		REG_YAW_LIM   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_ROLL  = 2'd0,
		AXIS_PITCH = 2'd1,
		AXIS_YAW   = 2'd2
	} axis_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MEAN,
		ST_MDIV,
		ST_MSET,
		ST_MUL,
		ST_ACC,
		ST_SDIV,
		ST_RSET,
		ST_ROOT,
		ST_STD,
		ST_NEXT,
		ST_DONE
	} state_t;

	// magnitude rounding to 8 fraction bits, half away from zero
	function automatic logic [PROD_W-1:0] rnd8(input logic [PROD_W-1:0] m);
		logic [PROD_W-1:0] t;
		t = m + PROD_W'(128);
		return t >> 8;
	endfunction

	function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [WK_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[WK_W-1:MEAN_W-1];
		hi_zeros = ~|v[WK_W-1:MEAN_W-1];
		if (hi_ones || hi_zeros)
			return v[MEAN_W-1:0];
		else if (v[WK_W-1])
			return {1'b1, {(MEAN_W-1){1'b0}}};
		else
			return {1'b0, {(MEAN_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUMX_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SUMX_W-1:SUM_W-1];
		hi_zeros = ~|v[SUMX_W-1:SUM_W-1];
		if (hi_ones || hi_zeros)
			return v[SUM_W-1:0];
		else if (v[SUMX_W-1])
			return {1'b1, {(SUM_W-1){1'b0}}};
		else
			return {1'b0, {(SUM_W-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/core/sliding_window_attitude_stats_unit.sv =====
// sequence: a clear or a sample without a statistics update goes from read to done; with
// an update each axis runs mean, the 48-step serial divider, multiply, accumulate, the
// divider again and root, the last two skipped when the sum goes negative
// flow: one word at a time; the next word can be taken in the cycle after the result is
// loaded into the output register, which waits until that register is free
// reset: count, slot, statistics, window valid bits clear; limits load 160/800/160
module sliding_window_attitude_stats_unit #(
	parameter int WINDOW_LEN = swas_pkg::WINDOW_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  swas_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output swas_pkg::out_word_t                 out_word,
	input  logic                                cfg_we,
	input  logic [swas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swas_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import swas_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_LEN);

	state_t state_q, state_d;
	in_word_t in_q;
	axis_t axis_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] slot_q;

	logic [3*SMP_W-1:0] mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] vld_q;
	logic [3*SMP_W-1:0] rd_q;
	logic rd_vld_q;

	logic signed [MEAN_W-1:0] mean_q [3];
	logic signed [SUM_W-1:0] sum_q [3];
	logic [STD_W-1:0] std_q [3];
	logic [LIM_W-1:0] lim_q [3];

	logic d_neg_q;
	logic [WK_W-1:0] d_mag_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] rem_q;
	logic [PROD_W-1:0] a_sh_q, p_q;
	logic [MB_W-1:0] b_q;
	logic p_neg_q;
	logic [DVD_W-1:0] v_q, r_q, bit_q;
	out_word_t out_q;
	logic out_valid_q;

	logic signed [XW-1:0] x_cur, old_cur;
	logic signed [WK_W-1:0] xs, olds, mean_ext, d_new, q_w, q_s, m1_ext, d2, fac;
	logic [WK_W-1:0] d_mag_new, d2_mag, fac_mag;
	logic d_neg_new, d2_neg, fac_neg, wf;
	logic [DVS_W-1:0] n_cur;
	logic [DVD_W-1:0] dvd_start;
	logic signed [MEAN_W-1:0] m1;
	logic [PROD_W-1:0] a_new, add_mag, mul_nx;
	logic [MB_W-1:0] b_new;
	logic p_neg_new;
	logic signed [SUMX_W-1:0] add_s;
	logic signed [SUM_W-1:0] sum_new;
	logic [DVS_W:0] rem_sh, rem_nx;
	logic div_ge;
	logic [DVD_W-1:0] trial;
	logic root_ge;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_comb begin
		case (axis_q)
			AXIS_ROLL: begin
				x_cur   = XW'($signed(in_q.roll_cdeg));
				old_cur = XW'($signed(rd_q[3*SMP_W-1:2*SMP_W]));
			end
			AXIS_PITCH: begin
				x_cur   = XW'($signed(in_q.pitch_cdeg));
				old_cur = XW'($signed(rd_q[2*SMP_W-1:SMP_W]));
			end
			AXIS_YAW: begin
				x_cur   = XW'($signed({1'b0, in_q.yaw_cdeg}));
				old_cur = XW'($signed({1'b0, rd_q[SMP_W-1:0]}));
			end
			default: begin
				x_cur   = '0;
				old_cur = '0;
			end
		endcase
		// never-written slots read as zero
		if (!rd_vld_q)
			old_cur = '0;

		xs       = $signed(WK_W'(x_cur)) <<< FRAC_SH;
		olds     = $signed(WK_W'(old_cur)) <<< FRAC_SH;
		mean_ext = WK_W'(mean_q[axis_q]);
		wf       = count_q <= CNT_W'(WINDOW_LEN);
		n_cur    = wf ? DVS_W'(count_q) : DVS_W'(WINDOW_LEN);

		d_new     = wf ? (xs - mean_ext) : (WK_W'(x_cur) - WK_W'(old_cur));
		d_neg_new = d_new[WK_W-1];
		d_mag_new = d_neg_new ? WK_W'(-d_new) : WK_W'(d_new);
		if (wf)
			dvd_start = DVD_W'(d_mag_new) + DVD_W'(n_cur >> 1);
		else
			dvd_start = (DVD_W'(d_mag_new) << FRAC_SH) + DVD_W'(WINDOW_LEN / 2);

		q_w    = WK_W'(dvd_q);
		q_s    = d_neg_q ? -q_w : q_w;
		m1     = sat_mean(mean_ext + q_s);
		m1_ext = WK_W'(m1);
		d2     = xs - m1_ext;
		d2_neg = d2[WK_W-1];
		d2_mag = d2_neg ? WK_W'(-d2) : WK_W'(d2);
		fac     = d2 + (olds - mean_ext);
		fac_neg = fac[WK_W-1];
		fac_mag = fac_neg ? WK_W'(-fac) : WK_W'(fac);
		if (wf) begin
			a_new     = rnd8(PROD_W'(d_mag_q));
			b_new     = MB_W'(rnd8(PROD_W'(d2_mag)));
			p_neg_new = d_neg_q ^ d2_neg;
		end else begin
			a_new     = PROD_W'(fac_mag);
			b_new     = MB_W'(d_mag_q);
			p_neg_new = fac_neg ^ d_neg_q;
		end

		mul_nx  = b_q[0] ? (p_q + a_sh_q) : p_q;
		add_mag = rnd8(p_q);
		add_s   = SUMX_W'(add_mag);
		if (p_neg_q)
			add_s = -add_s;
		sum_new = sat_sum(SUMX_W'(sum_q[axis_q]) + add_s);

		rem_sh = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
		div_ge = rem_sh >= {1'b0, dvs_q};
		rem_nx = div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

		trial   = r_q + bit_q;
		root_ge = v_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: begin
				if (!in_q.clear && in_q.advance && in_q.accumulate)
					state_d = ST_MEAN;
				else
					state_d = ST_DONE;
			end
			ST_MEAN: state_d = ST_MDIV;
			ST_MDIV: if (step_q == STEP_W'(DVD_W - 1)) state_d = ST_MSET;
			ST_MSET: state_d = ST_MUL;
			ST_MUL:  if (step_q == STEP_W'(MB_W - 1)) state_d = ST_ACC;
			ST_ACC: begin
				// negative sum keeps the previous deviation
				if (sum_new[SUM_W-1])
					state_d = ST_NEXT;
				else
					state_d = ST_SDIV;
			end
			ST_SDIV: if (step_q == STEP_W'(DVD_W - 1)) state_d = ST_RSET;
			ST_RSET: state_d = ST_ROOT;
			ST_ROOT: if (step_q == STEP_W'(ROOT_STEPS - 1)) state_d = ST_STD;
			ST_STD:  state_d = ST_NEXT;
			ST_NEXT: state_d = (axis_q == AXIS_YAW) ? ST_DONE : ST_MEAN;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			axis_q      <= AXIS_ROLL;
			count_q     <= '0;
			slot_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			lim_q[0]    <= LIM_W'(160);
			lim_q[1]    <= LIM_W'(800);
			lim_q[2]    <= LIM_W'(160);
			for (int k = 0; k < 3; k++) begin
				mean_q[k] <= '0;
				sum_q[k]  <= '0;
				std_q[k]  <= '0;
			end
		end else begin
			if (state_q == ST_MDIV || state_q == ST_MUL || state_q == ST_SDIV ||
			    state_q == ST_ROOT)
				step_q <= (state_d == state_q) ? step_q + STEP_W'(1) : '0;
			else
				step_q <= '0;

			if (cfg_we) begin
				case (cfg_index)
					REG_ROLL_LIM:  lim_q[0] <= cfg_data;
					REG_PITCH_LIM: lim_q[1] <= cfg_data;
					REG_YAW_LIM:   lim_q[2] <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_READ: begin
					axis_q <= AXIS_ROLL;
					if (in_q.clear) begin
						count_q <= '0;
						slot_q  <= '0;
						for (int k = 0; k < 3; k++) begin
							mean_q[k] <= '0;
							sum_q[k]  <= '0;
							std_q[k]  <= '0;
						end
					end else begin
						vld_q[slot_q] <= 1'b1;
						if (in_q.advance) begin
							if (count_q < CNT_W'(WINDOW_LEN + 1))
								count_q <= count_q + CNT_W'(1);
							slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0
							        : slot_q + SLOT_W'(1);
						end
					end
				end
				ST_MSET: mean_q[axis_q] <= m1;
				ST_ACC:  sum_q[axis_q] <= sum_new;
				ST_STD:  std_q[axis_q] <= (r_q > DVD_W'(STD_MAX)) ? STD_MAX : STD_W'(r_q);
				ST_NEXT: axis_q <= axis_t'(2'(axis_q) + 2'd1);
				default: ;
			endcase

			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// sample window, read before write at the same slot
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q     <= mem[slot_q];
			rd_vld_q <= vld_q[slot_q];
			if (!in_q.clear)
				mem[slot_q] <= {in_q.roll_cdeg, in_q.pitch_cdeg[14], in_q.pitch_cdeg,
				                in_q.yaw_cdeg};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) in_q <= in_word;
			ST_MEAN: begin
				d_neg_q <= d_neg_new;
				d_mag_q <= d_mag_new;
				dvd_q   <= dvd_start;
				dvs_q   <= n_cur;
				rem_q   <= '0;
			end
			ST_MDIV, ST_SDIV: begin
				dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
				rem_q <= rem_nx;
			end
			ST_MSET: begin
				a_sh_q  <= a_new;
				b_q     <= b_new;
				p_neg_q <= p_neg_new;
				p_q     <= '0;
			end
			ST_MUL: begin
				p_q    <= mul_nx;
				a_sh_q <= a_sh_q << 1;
				b_q    <= b_q >> 1;
			end
			ST_ACC: begin
				dvd_q <= DVD_W'(unsigned'(sum_new));
				dvs_q <= n_cur;
				rem_q <= '0;
			end
			ST_RSET: begin
				v_q   <= dvd_q;
				r_q   <= '0;
				bit_q <= DVD_W'(1) << (DVD_W - 2);
			end
			ST_ROOT: begin
				if (root_ge) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.roll_std     <= std_q[0];
					out_q.pitch_std    <= std_q[1];
					out_q.yaw_std      <= std_q[2];
					out_q.steady       <= (std_q[0] < STD_W'(lim_q[0])) &&
					                      (std_q[1] < STD_W'(lim_q[1])) &&
					                      (std_q[2] < STD_W'(lim_q[2]));
					out_q.samples_seen <= count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sliding_window_attitude_stats_unit_test.sv =====
module sliding_window_attitude_stats_unit_test;
	import swas_pkg::*;

	localparam int WIN = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sliding_window_attitude_stats_unit #(.WINDOW_LEN(WIN)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	longint win_smp [WIN][3];
	int unsigned n_seen;
	int unsigned slot;
	longint mean_q16 [3];
	longint sqsum_q8 [3];
	longint dev [3];
	longint std_lim [3];

	in_word_t words_pending [$];
	out_word_t stats_due [$];
	int fails = 0;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int gap_left = 0;
	int ostall_left = 0;
	int hold_left = 0;
	int roll_base, pitch_base, yaw_base;

	function automatic longint sat(longint v, longint hi);
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// round half away from zero of v / 256
	function automatic longint round_q8(longint v);
		if (v < 0) return -((128 - v) >>> 8);
		return (v + 128) >>> 8;
	endfunction

	function automatic longint div_round(longint v, longint n);
		if (v < 0) return -((n / 2 - v) / n);
		return (v + n / 2) / n;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic void refresh_dev(int k, longint n);
		longint s;
		if (sqsum_q8[k] < 0) return;
		s = int_sqrt(longint'(unsigned'(sqsum_q8[k]) / unsigned'(n)));
		dev[k] = (s > 524287) ? 524287 : s;
	endfunction

	function automatic out_word_t predict_stats(in_word_t w);
		longint x [3];
		longint prv, m0, m1, d1, d2, d, fac;
		int unsigned cur;
		out_word_t o;
		x[AXIS_ROLL] = longint'($signed(w.roll_cdeg));
		x[AXIS_PITCH] = longint'($signed(w.pitch_cdeg));
		x[AXIS_YAW] = longint'(w.yaw_cdeg);
		if (w.clear) begin
			n_seen = 0;
			slot = 0;
			for (int k = 0; k < 3; k++) begin
				mean_q16[k] = 0;
				sqsum_q8[k] = 0;
				dev[k] = 0;
			end
		end else begin
			cur = slot % WIN;
			if (w.advance) begin
				if (n_seen < WIN + 1) n_seen++;
				slot = (cur + 1) % WIN;
			end
			for (int k = 0; k < 3; k++) begin
				prv = win_smp[cur][k];
				m0 = mean_q16[k];
				win_smp[cur][k] = x[k];
				if (w.accumulate && w.advance) begin
					if (n_seen <= WIN) begin
						d1 = x[k] * 65536 - m0;
						m1 = sat(m0 + div_round(d1, n_seen), 64'h1FFFFFFFF);
						d2 = x[k] * 65536 - m1;
						mean_q16[k] = m1;
						sqsum_q8[k] = sat(sqsum_q8[k] + round_q8(round_q8(d1) * round_q8(d2)),
							64'h7FFFFFFFFFFF);
						refresh_dev(k, n_seen);
					end else begin
						// window full: retire the oldest sample
						d = x[k] - prv;
						m1 = sat(m0 + div_round(d * 65536, WIN), 64'h1FFFFFFFF);
						fac = (x[k] * 65536 - m1) + (prv * 65536 - m0);
						mean_q16[k] = m1;
						sqsum_q8[k] = sat(sqsum_q8[k] + round_q8(d * fac), 64'h7FFFFFFFFFFF);
						refresh_dev(k, WIN);
					end
				end
			end
		end
		o.roll_std = dev[AXIS_ROLL][STD_W-1:0];
		o.pitch_std = dev[AXIS_PITCH][STD_W-1:0];
		o.yaw_std = dev[AXIS_YAW][STD_W-1:0];
		o.steady = (dev[0] < std_lim[0]) && (dev[1] < std_lim[1]) && (dev[2] < std_lim[2]);
		o.samples_seen = n_seen[CNT_W-1:0];
		return o;
	endfunction

	function automatic void queue_sample(int r, int p, int y, bit adv, bit acc, bit clr);
		in_word_t w;
		w.roll_cdeg = r[15:0];
		w.pitch_cdeg = p[14:0];
		w.yaw_cdeg = y[15:0];
		w.advance = adv;
		w.accumulate = acc;
		w.clear = clr;
		words_pending.push_back(w);
	endfunction

	function automatic void queue_random(bit allow_clear);
		int mode, fl, r, p, y;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			r = $urandom;
			p = $urandom;
			y = $urandom;
		end else if (mode < 5) begin
			r = int'($urandom_range(0, 36000)) - 18000;
			p = int'($urandom_range(0, 18000)) - 9000;
			y = $urandom_range(0, 35999);
		end else begin
			// tight cluster so deviations land near the limits
			r = roll_base + int'($urandom_range(0, 80)) - 40;
			p = pitch_base + int'($urandom_range(0, 80)) - 40;
			y = yaw_base + int'($urandom_range(0, 80));
		end
		fl = $urandom_range(0, 19);
		queue_sample(r, p, y, fl < 18, fl < 17 || fl == 18,
			allow_clear && $urandom_range(0, 49) == 0);
	endfunction

	task automatic write_limit(cfg_reg_t idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[15:0];
		std_lim[idx] = v & 16'hFFFF;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (words_pending.size() != 0 || in_valid || stats_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// driver
	always @(posedge clk) begin : drv
		logic nv;
		in_word_t nw;
		if (arst_n) begin
			nv = in_valid;
			nw = in_word;
			if (in_valid && !in_stall) begin
				stats_due.push_back(predict_stats(in_word));
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (idle_en && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 6) - 1;
				else if (words_pending.size() > 0) begin
					nv = 1'b1;
					nw = words_pending.pop_front();
				end
			end
			in_valid <= nv;
			in_word <= nw;
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		logic ns;
		out_word_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (stats_due.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %h", $time, out_word);
					fails++;
				end else begin
					e = stats_due.pop_front();
					check_field("roll_std", e.roll_std, out_word.roll_std);
					check_field("pitch_std", e.pitch_std, out_word.pitch_std);
					check_field("yaw_std", e.yaw_std, out_word.yaw_std);
					check_field("steady", e.steady, out_word.steady);
					check_field("samples_seen", e.samples_seen, out_word.samples_seen);
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = 3000;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (ostall_left > 0) begin
				ostall_left--;
				ns = 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				ostall_left = $urandom_range(1, 6) - 1;
				ns = 1'b1;
			end else
				ns = 1'b0;
			out_stall <= ns;
		end
	end

	initial begin
		for (int i = 0; i < WIN; i++)
			for (int k = 0; k < 3; k++) win_smp[i][k] = 0;
		n_seen = 0;
		slot = 0;
		for (int k = 0; k < 3; k++) begin
			mean_q16[k] = 0;
			sqsum_q8[k] = 0;
			dev[k] = 0;
		end
		std_lim[0] = 160;
		std_lim[1] = 800;
		std_lim[2] = 160;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, flag combinations, clears
		queue_sample(0, 0, 0, 1, 1, 1);
		queue_sample(18000, 9000, 35999, 1, 1, 0);
		queue_sample(-18000, -9000, 0, 1, 1, 0);
		queue_sample(18000, 9000, 35999, 1, 1, 0);
		queue_sample(32767, 16383, 65535, 1, 1, 0);
		queue_sample(-32768, -16384, 0, 1, 1, 0);
		queue_sample(100, 100, 100, 0, 1, 0);
		queue_sample(-100, -100, 200, 1, 0, 0);
		queue_sample(5, 5, 5, 0, 0, 0);
		queue_sample(-1, -1, 65535, 1, 1, 1);
		queue_sample(10, 20, 30, 1, 1, 0);
		queue_sample(10, 20, 30, 1, 1, 0);
		queue_sample(10, 20, 30, 1, 1, 0);
		queue_sample(12, 18, 33, 1, 1, 0);
		queue_sample(-32768, -16384, 65535, 1, 1, 0);
		queue_sample(32767, 16383, 0, 1, 1, 0);
		queue_sample(0, 0, 0, 0, 1, 1);
		queue_sample(1, 1, 1, 1, 1, 0);
		drain();

		write_limit(REG_ROLL_LIM, 0);
		write_limit(REG_PITCH_LIM, 0);
		write_limit(REG_YAW_LIM, 0);
		queue_sample(0, 0, 0, 1, 1, 1);
		roll_base = 1200; pitch_base = -300; yaw_base = 9000;
		for (int i = 0; i < 150; i++) queue_random(1'b0);
		repeat (400) @(posedge clk);
		hold_req = 1'b1;
		drain();

		// keep counting across the phase so the window fills and slides
		write_limit(REG_ROLL_LIM, 65535);
		write_limit(REG_PITCH_LIM, 65535);
		write_limit(REG_YAW_LIM, 65535);
		roll_base = -5000; pitch_base = 4000; yaw_base = 30000;
		for (int i = 0; i < 150; i++) queue_random(1'b0);
		drain();

		write_limit(REG_ROLL_LIM, 300);
		write_limit(REG_PITCH_LIM, 1);
		write_limit(REG_YAW_LIM, 450);
		roll_base = 0; pitch_base = 0; yaw_base = 18000;
		idle_en = 1'b0;
		for (int i = 0; i < 150; i++) queue_random(1'b1);
		drain();
		repeat (500) @(posedge clk);

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/swas_pkg.sv
rtl/core/sliding_window_attitude_stats_unit.sv
tb/sliding_window_attitude_stats_unit_test.sv
